// File: hw/rtl/dpc_pkg.sv
// dpc_pkg: shared types and constants for the doubled pair counter.
// No dependencies; imported by dpc_cell and doubled_pair_counter.

package dpc_pkg;

    localparam int VALUE_W     = 32;          // width of one sequence element
    localparam int COUNT_W     = 19;          // width of the pair count
    localparam int MAX_LEN_DEF = 1024;        // default store capacity

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Control bits of a token moving down the cell row.
    typedef struct packed {
        logic valid;    // token present in this slot
        logic active;   // token was stored (store not full at entry)
        logic last;     // token closes the sequence
    } tok_ctrl_t;

endpackage

// File: hw/rtl/doubled_pair_counter.sv
// doubled_pair_counter: streaming count of pairs (earlier x, later y) with 2x <= y.
// Depends on dpc_pkg and dpc_cell.
//
//  channel | handshake          | payload            | direction
//  --------+--------------------+--------------------+----------
//  in      | in_valid, in_stall | value, last        | into block
//  out     | out_valid,out_stall| pair_count,too_long| out of block
//
// Cycles: one transaction accepted per cycle within a sequence. Each item
// becomes a token that walks the row of MAX_LEN cells, one cell per cycle,
// and out_valid rises from the output register once the last item's token
// has left the row; the row length sets the result latency.
// Stalls: after the last item in_stall stays high until the result has been
// taken on the out channel; the output register holds while out_stall is high.
// Reset: clears busy, out_valid, fill count, running count, overflow, token valids;
// stored cell values need no reset (a cell is read only after its write).

module doubled_pair_counter #(
    parameter int MAX_LEN = dpc_pkg::MAX_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [dpc_pkg::VALUE_W-1:0]  value,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dpc_pkg::COUNT_W-1:0]         pair_count,
    output logic                                too_long
);
    import dpc_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN + 1);
    localparam int HIT_W = $clog2(MAX_LEN);
    localparam logic [IDX_W-1:0] FULL = IDX_W'(MAX_LEN);

    // token row: slot k feeds cell k, slot MAX_LEN is the row exit
    tok_ctrl_t                 row_ctrl  [MAX_LEN+1];
    logic signed [VALUE_W-1:0] row_value [MAX_LEN+1];
    logic [IDX_W-1:0]          row_idx   [MAX_LEN+1];
    logic [HIT_W-1:0]          row_hits  [MAX_LEN+1];

    logic                 busy_reg,      busy_next;
    logic [IDX_W-1:0]     fill_reg,      fill_next;
    logic [COUNT_W-1:0]   running_reg,   running_next;
    logic                 overflow_reg,  overflow_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]   pair_count_reg, pair_count_next;
    logic                 too_long_reg,  too_long_next;

    logic                 in_accept;
    logic                 out_accept;
    logic                 has_room;
    logic [COUNT_W:0]     sum;
    logic [COUNT_W-1:0]   sum_sat;
    tok_ctrl_t            exit_ctrl;

    assign in_stall   = busy_reg;
    assign in_accept  = in_valid && !busy_reg;
    assign out_accept = out_valid_reg && !out_stall;
    assign has_room   = (fill_reg < FULL);

    // Row entry: a new token carries its target slot and an empty hit count.
    // Control order: valid, active, last.
    assign row_ctrl[0]  = {in_accept, has_room, last};
    assign row_value[0] = value;
    assign row_idx[0]   = fill_reg;
    assign row_hits[0]  = '0;

    for (genvar k = 0; k < MAX_LEN; k++)
    begin : g_cell
        dpc_cell #(
            .MAX_LEN  (MAX_LEN),
            .CELL_IDX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl_in   (row_ctrl[k]),
            .value_in  (row_value[k]),
            .idx_in    (row_idx[k]),
            .hits_in   (row_hits[k]),
            .ctrl_out  (row_ctrl[k+1]),
            .value_out (row_value[k+1]),
            .idx_out   (row_idx[k+1]),
            .hits_out  (row_hits[k+1])
        );
    end

    assign exit_ctrl = row_ctrl[MAX_LEN];

    // Saturating accumulate of the hits a token collected along the row.
    always_comb
    begin
        sum     = {1'b0, running_reg} + (COUNT_W+1)'(row_hits[MAX_LEN]);
        sum_sat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    end

    always_comb
    begin
        busy_next       = busy_reg;
        fill_next       = fill_reg;
        running_next    = running_reg;
        overflow_next   = overflow_reg;
        out_valid_next  = out_valid_reg;
        pair_count_next = pair_count_reg;
        too_long_next   = too_long_reg;

        if (out_accept)
        begin
            out_valid_next = 1'b0;
            busy_next      = 1'b0;
        end

        if (in_accept)
        begin
            if (!has_room)
            begin
                overflow_next = 1'b1;
            end
            priority if (last)
            begin
                // tokens already carry their slots; next sequence starts empty
                busy_next = 1'b1;
                fill_next = '0;
            end
            else if (has_room)
            begin
                fill_next = fill_reg + IDX_W'(1);
            end
            else
            begin
                // store full: item dropped, fill count holds
                fill_next = fill_reg;
            end
        end

        if (exit_ctrl.valid)
        begin
            if (exit_ctrl.last)
            begin
                // all earlier tokens have left the row in order
                out_valid_next  = 1'b1;
                pair_count_next = sum_sat;
                too_long_next   = overflow_reg;
                running_next    = '0;
                overflow_next   = 1'b0;
            end
            else
            begin
                running_next = sum_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            fill_reg      <= '0;
            running_reg   <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            fill_reg      <= fill_next;
            running_reg   <= running_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_count_reg <= pair_count_next;
        too_long_reg   <= too_long_next;
    end

    assign out_valid  = out_valid_reg;
    assign pair_count = pair_count_reg;
    assign too_long   = too_long_reg;

endmodule

// File: hw/rtl/dpc_cell.sv
// dpc_cell: one cell of the compare row; holds one stored value.
// Depends on dpc_pkg. Instantiated by doubled_pair_counter.

module dpc_cell #(
    parameter int MAX_LEN  = dpc_pkg::MAX_LEN_DEF,
    parameter int CELL_IDX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dpc_pkg::tok_ctrl_t                  ctrl_in,
    input  logic signed [dpc_pkg::VALUE_W-1:0]  value_in,
    input  logic [$clog2(MAX_LEN+1)-1:0]        idx_in,
    input  logic [$clog2(MAX_LEN)-1:0]          hits_in,
    output dpc_pkg::tok_ctrl_t                  ctrl_out,
    output logic signed [dpc_pkg::VALUE_W-1:0]  value_out,
    output logic [$clog2(MAX_LEN+1)-1:0]        idx_out,
    output logic [$clog2(MAX_LEN)-1:0]          hits_out
);
    import dpc_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN + 1);
    localparam int HIT_W = $clog2(MAX_LEN);
    localparam logic [IDX_W-1:0] CELL_K = IDX_W'(CELL_IDX);

    logic signed [VALUE_W-1:0] x_reg;
    tok_ctrl_t                 ctrl_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [HIT_W-1:0]          hits_reg;

    logic signed [VALUE_W:0]   x2;
    logic signed [VALUE_W:0]   y_ext;
    logic                      hit;
    logic                      store;
    logic [HIT_W-1:0]          hits_next;

    always_comb
    begin
        x2        = {x_reg, 1'b0};
        y_ext     = {value_in[VALUE_W-1], value_in};
        // only entries below the token's own slot were written earlier
        hit       = ctrl_in.valid && ctrl_in.active && (CELL_K < idx_in)
                    && (x2 <= y_ext);
        store     = ctrl_in.valid && ctrl_in.active && (idx_in == CELL_K);
        hits_next = hits_in + HIT_W'(hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_in;
        idx_reg   <= idx_in;
        hits_reg  <= hits_next;
        if (store)
        begin
            x_reg <= value_in;
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign value_out = value_reg;
    assign idx_out   = idx_reg;
    assign hits_out  = hits_reg;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

// testbench: self-checking bench for doubled_pair_counter, directed table then random sequences.
// Depends on dpc_pkg and the doubled_pair_counter RTL; a local pair-count predictor is the reference.

module testbench;
    import dpc_pkg::*;

    // Store depth under test; the predictor and the instance share it.
    localparam int STORE_DEPTH    = MAX_LEN_DEF;
    localparam int RANDOM_ITEMS   = 1680;
    localparam int IDLE_PCT       = 36;
    // A result trails its last transaction by the walk down the store row, plus receiver stalls.
    localparam int WATCHDOG_LIMIT = 4 * (STORE_DEPTH + 100);
    localparam int TAIL_CYCLES    = STORE_DEPTH + 16;
    localparam int EXTRA_ITEMS    = 4;    // items pushed past a full store

    localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFF_FFFF;

    localparam logic signed [VALUE_W-1:0] EDGE_VALUES [10] = '{
        32'sh8000_0000, 32'sh8000_0001, 32'shBFFF_FFFF, 32'shC000_0000, 32'shFFFF_FFFF,
        32'sh0000_0000, 32'sh0000_0001, 32'sh3FFF_FFFF, 32'sh4000_0000, 32'sh7FFF_FFFF
    };

    typedef enum int {
        MODE_FULL,      // any 32-bit value
        MODE_SMALL,     // -8..8, dense hits and equal pairs
        MODE_EDGE,      // range limits and the doubling boundaries
        MODE_DOUBLED    // twice the previous value, +-1
    } value_mode_e;

    // One row of the directed table. typed rows carry a hand-worked result.
    typedef struct packed {
        logic signed [VALUE_W-1:0] val;
        logic                      closes;
        logic                      typed;
        logic [COUNT_W-1:0]        want_pairs;
        logic                      want_over;
    } stim_row_t;

    typedef struct packed {
        logic [COUNT_W-1:0] pairs;
        logic               too_long;
    } pair_result_t;

    localparam int DIRECTED_ROWS = 21;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // lone item: nothing earlier to pair with
        '{32'sh0000_0000, 1'b1, 1'b1, 19'd0, 1'b0},
        // min then max: 2*min = -2^32 <= max
        '{V_MIN,          1'b0, 1'b0, 19'd0, 1'b0},
        '{V_MAX,          1'b1, 1'b1, 19'd1, 1'b0},
        // max then min: never
        '{V_MAX,          1'b0, 1'b0, 19'd0, 1'b0},
        '{V_MIN,          1'b1, 1'b1, 19'd0, 1'b0},
        // min twice: holds only if the doubling does not wrap to zero
        '{V_MIN,          1'b0, 1'b0, 19'd0, 1'b0},
        '{V_MIN,          1'b1, 1'b1, 19'd1, 1'b0},
        // max twice: fails only if the doubling does not wrap to -2
        '{V_MAX,          1'b0, 1'b0, 19'd0, 1'b0},
        '{V_MAX,          1'b1, 1'b1, 19'd0, 1'b0},
        // equality counts, one below does not
        '{32'sd5,         1'b0, 1'b0, 19'd0, 1'b0},
        '{32'sd10,        1'b0, 1'b0, 19'd0, 1'b0},
        '{32'sd9,         1'b1, 1'b1, 19'd1, 1'b0},
        // negative equality
        '{-32'sd3,        1'b0, 1'b0, 19'd0, 1'b0},
        '{-32'sd6,        1'b1, 1'b1, 19'd1, 1'b0},
        // all -1: every pair counts, 4 choose 2
        '{-32'sd1,        1'b0, 1'b0, 19'd0, 1'b0},
        '{-32'sd1,        1'b0, 1'b0, 19'd0, 1'b0},
        '{-32'sd1,        1'b0, 1'b0, 19'd0, 1'b0},
        '{-32'sd1,        1'b1, 1'b1, 19'd6, 1'b0},
        // alternating bit patterns, predictor checked
        '{32'sh5555_5555, 1'b0, 1'b0, 19'd0, 1'b0},
        '{32'shAAAA_AAAA, 1'b0, 1'b0, 19'd0, 1'b0},
        '{32'sh7FFF_0000, 1'b1, 1'b0, 19'd0, 1'b0}
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic signed [VALUE_W-1:0] value     = '0;
    logic                      last      = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [COUNT_W-1:0]        pair_count;
    logic                      too_long;

    // Side-band of the transaction in flight: hand-worked result, if any.
    logic                      cur_typed      = 1'b0;
    logic [COUNT_W-1:0]        cur_want_pairs = '0;
    logic                      cur_want_over  = 1'b0;

    logic                      steady = 1'b0;   // no idling on either side while set
    int                        fail_count  = 0;
    int                        quiet_cycles = 0;
    int                        random_sent = 0;
    logic signed [VALUE_W-1:0] prev_value = '0;

    // Predictor state: values of the open sequence, pair count, overflow mark.
    logic signed [VALUE_W-1:0] seen_values [STORE_DEPTH];
    int unsigned               seen_count    = 0;
    logic [COUNT_W-1:0]        doubled_pairs = '0;
    logic                      seq_too_long  = 1'b0;
    pair_result_t              expected_results [$];

    always #6 clk = ~clk;

    doubled_pair_counter #(
        .MAX_LEN    (STORE_DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pair_count (pair_count),
        .too_long   (too_long)
    );

    // Unless the store is full, count earlier x with 2x <= y (exact, 64-bit) and store y;
    // on the closing item queue the result and start a fresh sequence.
    function automatic void absorb_value(input logic signed [VALUE_W-1:0] y,
                                         input logic closes, input logic typed,
                                         input logic [COUNT_W-1:0] want_pairs,
                                         input logic want_over);
        int unsigned  hits;
        pair_result_t res;
        if (seen_count < STORE_DEPTH) begin
            hits = 0;
            for (int k = 0; k < seen_count; k++) begin
                if (2 * longint'(seen_values[k]) <= longint'(y))
                    hits++;
            end
            // saturate; unreachable at depth 1024 but kept for larger stores
            if (longint'(hits) + longint'(doubled_pairs) > longint'(COUNT_MAX))
                doubled_pairs = COUNT_MAX;
            else
                doubled_pairs = doubled_pairs + hits[COUNT_W-1:0];
            seen_values[seen_count] = y;
            seen_count++;
        end
        else begin
            // store full: item ignored, only the flag remembers it
            seq_too_long = 1'b1;
        end
        if (closes) begin
            res.pairs    = typed ? want_pairs : doubled_pairs;
            res.too_long = typed ? want_over  : seq_too_long;
            expected_results.push_back(res);
            seen_count    = 0;
            doubled_pairs = '0;
            seq_too_long  = 1'b0;
        end
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value(input value_mode_e mode);
        longint                    near;
        logic signed [VALUE_W-1:0] v;
        case (mode)
            MODE_SMALL:
                v = VALUE_W'(int'($urandom_range(0, 16)) - 8);
            MODE_EDGE:
                v = EDGE_VALUES[$urandom_range(0, 9)];
            MODE_DOUBLED:
            begin
                // land on or next to the 2x boundary of the last value sent
                near = 2 * longint'(prev_value) + longint'($urandom_range(0, 2)) - 1;
                if (near >= longint'(V_MIN) && near <= longint'(V_MAX))
                    v = near[VALUE_W-1:0];
                else
                    v = $urandom;
            end
            default:
                v = $urandom;
        endcase
        prev_value = v;
        return v;
    endfunction

    // Drive one transaction from a falling edge; idles first at random.
    // Payload holds until the rising edge where in_stall is low.
    task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic closes,
                             input logic typed, input logic [COUNT_W-1:0] want_pairs,
                             input logic want_over);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        value          <= v;
        last           <= closes;
        cur_typed      <= typed;
        cur_want_pairs <= want_pairs;
        cur_want_over  <= want_over;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_sequence(input int unsigned len, input value_mode_e mode);
        for (int unsigned i = 0; i < len; i++) begin
            send_item(pick_value(mode), i == len - 1, 1'b0, '0, 1'b0);
            random_sent++;
        end
    endtask

    // Receiver: random stalls, none during the steady stretch.
    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);

    // Sample both channels at the rising edge: feed the predictor with every
    // accepted transaction, check every accepted result, watch for a hang.
    always @(posedge clk) begin
        pair_result_t want;
        if (rst_n) begin
            if (in_valid && !in_stall)
                absorb_value(value, last, cur_typed, cur_want_pairs, cur_want_over);
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: pair_count=%0d too_long=%0b",
                           pair_count, too_long);
                    fail_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (pair_count !== want.pairs) begin
                        $error("pair_count: expected %0d, got %0d", want.pairs, pair_count);
                        fail_count++;
                    end
                    if (too_long !== want.too_long) begin
                        $error("too_long: expected %0b, got %0b", want.too_long, too_long);
                        fail_count++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("FAIL doubled_pair_counter");
                    $finish;
                end
            end
        end
    end

    initial begin
        int unsigned seq_len;
        value_mode_e mode;
        logic        long_done;
        long_done = 1'b0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(DIRECTED[r].val, DIRECTED[r].closes, DIRECTED[r].typed,
                      DIRECTED[r].want_pairs, DIRECTED[r].want_over);

        // random sequences, mostly short to keep the per-result drain cheap
        while (random_sent < RANDOM_ITEMS) begin
            steady = (random_sent >= 100 && random_sent < 260);
            if (!long_done && random_sent >= 350) begin
                // fill the store with -1 (every pair counts, the largest count a full store gives),
                // then push past capacity; the closing item is one of the ignored
                for (int i = 0; i < STORE_DEPTH + EXTRA_ITEMS; i++) begin
                    if (i < STORE_DEPTH)
                        send_item(-32'sd1, 1'b0, 1'b0, '0, 1'b0);
                    else
                        send_item($urandom, i == STORE_DEPTH + EXTRA_ITEMS - 1,
                                  1'b0, '0, 1'b0);
                    random_sent++;
                end
                long_done = 1'b1;
            end
            else begin
                seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                      : $urandom_range(1, 20);
                mode = value_mode_e'($urandom_range(0, 3));
                send_sequence(seq_len, mode);
            end
        end
        steady   = 1'b0;
        in_valid <= 1'b0;

        // drain, then give a stray result time to show up
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS doubled_pair_counter");
        else
            $display("FAIL doubled_pair_counter");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dpc_pkg.sv
hw/rtl/dpc_cell.sv
hw/rtl/doubled_pair_counter.sv
sim/testbench.sv
